FILE: hw/rtl/oqkr_pkg.sv
`default_nettype none

package oqkr_pkg;

  localparam int KEY_W = 16;
  localparam int HDL_W = 16;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [HDL_W-1:0] handle;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/oqkr_ram.sv
`default_nettype none

module oqkr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_queue_keyed_removal.sv
// Ordered queue of up to DEPTH records, each a 16-bit key and a 16-bit handle.
// The input channel carries one operation per transfer: insert at the tail,
// remove the first record with a matching key, or search for it. Every input
// transfer yields exactly one result transfer with the found flag, the matched
// handle, a status code, the occupancy and an empty flag.
// Insert and no-op results need no scan: the operation passes from the start
// step straight to the finish step. Remove and search scan the queue from the
// head through one registered-read RAM port and a single key comparator, one
// entry per cycle; a remove then shifts each following record down by one entry
// per cycle through the same port. A search stops at the first matching record;
// a miss scans all count records, at most DEPTH, where count is the occupancy
// before the operation. The input is ready again in the cycle after the result
// is loaded.
// The next input is accepted once the result has been placed in the output
// register, so a waiting result does not block the next operation; only a
// second result waiting behind a stalled receiver holds the block.
// Reset empties the queue and drops any pending result. The RAM contents are
// not cleared; only entries below the occupancy are ever compared or copied.
`default_nettype none

module ordered_queue_keyed_removal
  import oqkr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst_n,
  input  wire logic                                              in_tvalid,
  output logic                                                   in_tready,
  // key [15:0], record_handle [31:16]
  input  wire logic [KEY_W+HDL_W-1:0]                            in_tdata,
  // operation [1:0]
  input  wire logic [OP_W-1:0]                                   in_tuser,
  output logic                                                   out_tvalid,
  input  wire logic                                              out_tready,
  // found [0], handle_out [16:1], status [18:17], occupancy, empty_res, zero padding
  output logic [((HDL_W+ST_W+$clog2(DEPTH+1)+9)/8)*8-1:0]        out_tdata
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int OUT_DW = ((HDL_W + ST_W + CNT_W + 9) / 8) * 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [HDL_W-1:0]  hdl_r, hdl_nxt;
  logic              found_r, found_nxt;
  logic [HDL_W-1:0]  hout_r, hout_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;

  logic [CNT_W-1:0]  idx_plus1;
  logic [CNT_W-1:0]  idx_plus2;
  logic              in_xfer;

  assign idx_plus1 = idx_r + CNT_W'(1);
  assign idx_plus2 = idx_r + CNT_W'(2);
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  oqkr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    hdl_nxt       = hdl_r;
    found_nxt     = found_r;
    hout_nxt      = hout_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[IDX_W-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_tuser;
          key_nxt   = in_tdata[KEY_W-1:0];
          hdl_nxt   = in_tdata[KEY_W+HDL_W-1:KEY_W];
          state_nxt = S_START;
        end
      end
      S_START: begin
        found_nxt  = 1'b0;
        hout_nxt   = '0;
        status_nxt = ST_OK;
        idx_nxt    = '0;
        state_nxt  = S_FIN;
        case (op_r)
          OP_INSERT: begin
            if (cnt_r == CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we           = 1'b1;
              ram_waddr        = cnt_r[IDX_W-1:0];
              ram_wdata.key    = key_r;
              ram_wdata.handle = hdl_r;
              cnt_nxt          = cnt_r + CNT_W'(1);
            end
          end
          OP_REMOVE, OP_SEARCH: begin
            if (cnt_r == '0) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        ram_raddr = idx_plus1[IDX_W-1:0];
        if (ram_rdata.key == key_r) begin
          found_nxt = 1'b1;
          hout_nxt  = ram_rdata.handle;
          state_nxt = S_FIN;
          if (op_r == OP_REMOVE) begin
            if (idx_plus1 == cnt_r) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end else begin
              state_nxt = S_SHIFT;
            end
          end
        end else if (idx_plus1 == cnt_r) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_FIN;
        end else begin
          idx_nxt = idx_plus1;
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_plus2[IDX_W-1:0];
        if (idx_plus2 == cnt_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_plus1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DW'({(cnt_r == '0), cnt_r, status_r, hout_r, found_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    hdl_r      <= hdl_nxt;
    found_r    <= found_nxt;
    hout_r     <= hout_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("occupancy exceeds the queue depth");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_plus1 < cnt_r))
    else $error("shift index runs past the last record");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result loaded outside the finish step");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_START))
    else $error("accepted operation did not start");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_ordered_queue_keyed_removal.sv
`timescale 1ns / 1ps

module tb_ordered_queue_keyed_removal;
  import oqkr_pkg::*;

  localparam int DEPTH = 16;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int OUT_W = ((HDL_W + ST_W + OCC_W + 9) / 8) * 8;
  localparam logic [OP_W-1:0] OP_IDLE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic             found;
    logic [HDL_W-1:0] handle;
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occupancy;
    logic             empty;
  } queue_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [KEY_W+HDL_W-1:0] in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = OP_INSERT;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_W-1:0]       out_tdata;

  logic [KEY_W-1:0] shadow_keys[$];
  logic [HDL_W-1:0] shadow_handles[$];
  queue_result_t    pending_results[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_found = 0;
  int n_missed = 0;
  int n_dropped = 0;
  int n_idle_ops = 0;

  ordered_queue_keyed_removal #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.found     = out_tdata[0];
      got.handle    = out_tdata[16:1];
      got.status    = out_tdata[18:17];
      got.occupancy = out_tdata[19 +: OCC_W];
      got.empty     = out_tdata[19 + OCC_W];
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result transfer: found=%0b handle=%h status=%0d occ=%0d empty=%0b",
                   got.found, got.handle, got.status, got.occupancy, got.empty);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.handle !== want.handle ||
            got.status !== want.status || got.occupancy !== want.occupancy ||
            got.empty !== want.empty) begin
          errors++;
          if (errors <= 10) begin
            $display("Result %0d: expected found=%0b handle=%h status=%0d occ=%0d empty=%0b",
                     n_checked, want.found, want.handle, want.status, want.occupancy,
                     want.empty);
            $display("Result %0d: actual   found=%0b handle=%h status=%0d occ=%0d empty=%0b",
                     n_checked, got.found, got.handle, got.status, got.occupancy, got.empty);
          end
        end
      end
      n_checked++;
    end
  end

  task automatic predict_queue_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                  input logic [HDL_W-1:0] handle);
    queue_result_t r;
    int hit;
    int i;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    if (op == OP_INSERT) begin
      if (shadow_keys.size() >= DEPTH) begin
        r.status = ST_FULL;
        n_dropped++;
      end else begin
        shadow_keys.push_back(key);
        shadow_handles.push_back(handle);
      end
    end else if (op == OP_REMOVE || op == OP_SEARCH) begin
      for (i = shadow_keys.size() - 1; i >= 0; i--) begin
        if (shadow_keys[i] == key) hit = i;
      end
      if (hit >= 0) begin
        r.found = 1'b1;
        r.handle = shadow_handles[hit];
        n_found++;
        if (op == OP_REMOVE) begin
          shadow_keys.delete(hit);
          shadow_handles.delete(hit);
        end
      end else begin
        r.status = ST_NOT_FOUND;
        n_missed++;
      end
    end else begin
      n_idle_ops++;
    end
    r.occupancy = OCC_W'(shadow_keys.size());
    r.empty = (shadow_keys.size() == 0);
    pending_results.push_back(r);
  endtask

  task automatic push_operation(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [HDL_W-1:0] handle);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {handle, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_queue_op(op, key, handle);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_ops(input int count, input int src_pct, input int sink_pct);
    logic [KEY_W-1:0] pool[6];
    logic [KEY_W-1:0] key;
    logic [OP_W-1:0]  op;
    int i;
    int r;
    int ins_pct;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    foreach (pool[j]) pool[j] = KEY_W'($urandom);
    for (i = 0; i < count; i++) begin
      // Alternate fill-biased and drain-biased stretches so the queue swings
      // between empty and full.
      ins_pct = ((i / 40) % 2 == 0) ? 70 : 20;
      r = $urandom_range(99);
      if (r < 3) op = OP_IDLE;
      else if (r < 3 + ins_pct) op = OP_INSERT;
      else if ($urandom_range(2) != 0) op = OP_REMOVE;
      else op = OP_SEARCH;
      r = $urandom_range(99);
      if (op != OP_INSERT && shadow_keys.size() > 0 && r < 70) begin
        key = shadow_keys[$urandom_range(shadow_keys.size() - 1)];
      end else if (r < 90) begin
        key = pool[$urandom_range(5)];
      end else begin
        key = KEY_W'($urandom);
      end
      push_operation(op, key, HDL_W'($urandom));
    end
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    push_operation(OP_REMOVE, 16'h1234, 16'h0000);
    push_operation(OP_SEARCH, 16'hFFFF, 16'hFFFF);
    push_operation(OP_IDLE, 16'hFFFF, 16'hFFFF);
    push_operation(OP_INSERT, 16'h0000, 16'hFFFF);
    push_operation(OP_INSERT, 16'hFFFF, 16'h0000);
    push_operation(OP_INSERT, 16'h0000, 16'h5A5A);
    push_operation(OP_INSERT, 16'h8001, 16'h7FFE);
    push_operation(OP_SEARCH, 16'h0000, 16'h0000);
    push_operation(OP_SEARCH, 16'h8001, 16'h0000);
    push_operation(OP_SEARCH, 16'h4321, 16'h0000);
    push_operation(OP_IDLE, 16'h0000, 16'h0000);
    push_operation(OP_REMOVE, 16'h0000, 16'h0000);
    push_operation(OP_SEARCH, 16'h0000, 16'h0000);
    push_operation(OP_REMOVE, 16'h0000, 16'hFFFF);
    push_operation(OP_REMOVE, 16'h8001, 16'h0000);
    push_operation(OP_REMOVE, 16'h8001, 16'h0000);
    push_operation(OP_REMOVE, 16'hFFFF, 16'h0000);
    push_operation(OP_SEARCH, 16'hFFFF, 16'h0000);
    wait_drained();
  endtask

  task automatic test_full_queue();
    logic [KEY_W-1:0] key;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    while (shadow_keys.size() < DEPTH) begin
      push_operation(OP_INSERT, KEY_W'($urandom), HDL_W'($urandom));
    end
    push_operation(OP_INSERT, 16'hFFFF, 16'hFFFF);
    push_operation(OP_INSERT, 16'h0000, 16'h0000);
    push_operation(OP_IDLE, 16'h0000, 16'h0000);
    push_operation(OP_SEARCH, shadow_keys[DEPTH-1], 16'h0000);
    push_operation(OP_REMOVE, shadow_keys[DEPTH-1], 16'h0000);
    while (shadow_keys.size() > 0) begin
      key = shadow_keys[$urandom_range(shadow_keys.size() - 1)];
      push_operation(OP_REMOVE, key, HDL_W'($urandom));
    end
    push_operation(OP_REMOVE, KEY_W'($urandom), HDL_W'($urandom));
    wait_drained();
  endtask

  task automatic test_no_idling();
    random_ops(400, 0, 0);
    wait_drained();
  endtask

  task automatic test_sender_gaps();
    random_ops(300, 79, 0);
    wait_drained();
  endtask

  task automatic test_receiver_stalls();
    random_ops(300, 0, 79);
    wait_drained();
  endtask

  task automatic test_both_idle();
    random_ops(350, 14, 14);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering transfers, so the block fills and holds its input low.
  task automatic test_backpressure();
    hold_seq = hold_seq + 1;
    random_ops(30, 0, 0);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) errors++;
    $display("Covered %0d operations and %0d results: %0d matches, %0d misses,",
             n_sent, n_checked, n_found, n_missed);
    $display("%0d inserts dropped on a full queue, %0d no-ops, %0d failures.",
             n_dropped, n_idle_ops, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/oqkr_pkg.sv
hw/rtl/oqkr_ram.sv
hw/rtl/ordered_queue_keyed_removal.sv
verif/tb_ordered_queue_keyed_removal.sv
